@@ sv/rbf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbf_pkg
// Shared constants and controller/datapath handshake types for the row box
// filter.
// ---------------------------------------------------------------------------
package rbf_pkg;

    localparam int DEF_MAX_RADIUS     = 32;
    localparam int DEF_MAX_ROW_PIXELS = 65536;

    localparam int RAD_W   = 6;
    localparam int CC_W    = 3;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 4;
    localparam int PIX_W   = CHAN_W * NCHAN;
    localparam int CFG_A_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_A_W-1:0] REG_RADIUS        = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;     // take the input word into history
        logic plan;       // set the first window offset
        logic setup;      // prepare one window sweep
        logic issue;      // read one history entry
        logic div_start;  // load the divider
        logic out_load;   // write the result into the output register
        logic dec_d;      // step to the next window offset
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic need_emit;   // this pixel causes at least one result
        logic last_issue;  // current read is the oldest pixel of the window
        logic div_done;    // quotients are ready
        logic out_free;    // output register can take a word
        logic emit_done;   // current result is the last of this pixel
    } t_status;

endpackage

@@ sv/rbf_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbf_ctrl
// Sequencer for the row box filter: accept a pixel, then for each owed
// result sweep the window, divide and hand the word to the output register.
// ---------------------------------------------------------------------------
module rbf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rbf_pkg::t_status i_status,
    output rbf_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PLAN   = 8'b0000_0010,
        S_SETUP  = 8'b0000_0100,
        S_SUM    = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_DIV_LD = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PLAN;
                end
            end
            S_PLAN: begin
                if (i_status.need_emit) begin
                    o_cmd.plan = 1'b1;
                    n_state    = S_SETUP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DIV_LD;
            end
            S_DIV_LD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.emit_done) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dec_d = 1'b1;
                        n_state     = S_SETUP;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/rbf_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbf_dp
// Datapath of the row box filter: pixel history memory, row position,
// window accumulators, four restoring dividers and the output register.
// ---------------------------------------------------------------------------
module rbf_dp #(
    parameter int MAX_RADIUS     = rbf_pkg::DEF_MAX_RADIUS,
    parameter int MAX_ROW_PIXELS = rbf_pkg::DEF_MAX_ROW_PIXELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rbf_pkg::t_cmd               i_cmd,
    output rbf_pkg::t_status            o_status,
    input  logic [rbf_pkg::PIX_W-1:0]   i_pix,
    input  logic                        i_row_end,
    input  logic [rbf_pkg::RAD_W-1:0]   i_radius,
    input  logic [rbf_pkg::CC_W-1:0]    i_channel_count,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rbf_pkg::PIX_W-1:0]   o_out_data,
    output logic                        o_out_last
);

    localparam int HIST_D = 2 * MAX_RADIUS + 2;
    localparam int AW     = $clog2(HIST_D);
    localparam int CNT_W  = $clog2(HIST_D);
    localparam int SUM_W  = CNT_W + rbf_pkg::CHAN_W;
    localparam int DC_W   = $clog2(SUM_W + 1);
    localparam int POS_W  = $clog2(MAX_ROW_PIXELS);
    localparam int RAD_W  = rbf_pkg::RAD_W;
    localparam int CW     = rbf_pkg::CHAN_W;
    localparam int NCH    = rbf_pkg::NCHAN;

    logic [rbf_pkg::PIX_W-1:0] r_mem [HIST_D];
    logic [AW-1:0]             r_wp;
    logic [AW-1:0]             r_rp;
    logic [POS_W-1:0]          r_pos;
    logic [POS_W-1:0]          r_n_m1;
    logic [RAD_W-1:0]          r_r;
    logic [rbf_pkg::CC_W-1:0]  r_cc;
    logic                      r_row_end;
    logic [RAD_W-1:0]          r_d;
    logic [CNT_W-1:0]          r_hi;
    logic [CNT_W-1:0]          r_k;
    logic                      r_rd_vld;
    logic [rbf_pkg::PIX_W-1:0] r_rd_data;
    logic [SUM_W-1:0]          r_acc [NCH];
    logic [SUM_W-1:0]          r_quo [NCH];
    logic [CNT_W-1:0]          r_rem [NCH];
    logic [CNT_W-1:0]          r_div;
    logic [DC_W-1:0]           r_dcnt;
    logic                      r_out_valid;
    logic [rbf_pkg::PIX_W-1:0] r_out_data;
    logic                      r_out_last;

    logic [AW-1:0]             wp_nx;
    logic [POS_W-1:0]          n_cur;
    logic [RAD_W-1:0]          r_eff;
    logic [rbf_pkg::CC_W-1:0]  cc_eff;
    logic [CNT_W-1:0]          hi_nx;
    logic [RAD_W-1:0]          d_first;
    logic [rbf_pkg::PIX_W-1:0] out_word;

    // window offsets and clamps
    always_comb begin
        wp_nx   = (r_wp == AW'(HIST_D - 1)) ? '0 : r_wp + 1'b1;
        n_cur   = (32'(r_pos) < 32'(MAX_ROW_PIXELS - 1)) ? r_pos + 1'b1 : r_pos;
        r_eff   = (32'(i_radius) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_radius;
        if (i_channel_count == '0) begin
            cc_eff = rbf_pkg::CC_W'(1);
        end else if (32'(i_channel_count) > 32'(NCH)) begin
            cc_eff = rbf_pkg::CC_W'(NCH);
        end else begin
            cc_eff = i_channel_count;
        end
        d_first = (32'(r_r) > 32'(r_n_m1)) ? RAD_W'(r_n_m1) : r_r;
        if (32'(r_d) + 32'(r_r) > 32'(r_n_m1)) begin
            hi_nx = CNT_W'(r_n_m1);
        end else begin
            hi_nx = CNT_W'(32'(r_d) + 32'(r_r));
        end
    end

    // status to the controller
    always_comb begin
        o_status.need_emit  = r_row_end || (32'(r_n_m1) >= 32'(r_r));
        o_status.last_issue = (r_k == r_hi);
        o_status.div_done   = (r_dcnt == '0);
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.emit_done  = !r_row_end || (r_d == '0);
    end

    // history write and window reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[wp_nx] <= i_pix;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // row position, write pointer, read-valid flag and divider counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_pos    <= '0;
            r_rd_vld <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.accept) begin
                r_wp  <= wp_nx;
                r_pos <= i_row_end ? '0 : n_cur;
            end
            if (i_cmd.div_start) begin
                r_dcnt <= DC_W'(SUM_W);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    // per pixel and per window scratch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_n_m1    <= n_cur - 1'b1;
            r_r       <= r_eff;
            r_cc      <= cc_eff;
            r_row_end <= i_row_end;
        end
        if (i_cmd.plan) begin
            r_d <= d_first;
        end else if (i_cmd.dec_d) begin
            r_d <= r_d - 1'b1;
        end
        if (i_cmd.setup) begin
            r_hi <= hi_nx;
            r_k  <= '0;
            r_rp <= r_wp;
        end else if (i_cmd.issue) begin
            r_k  <= r_k + 1'b1;
            r_rp <= (r_rp == '0) ? AW'(HIST_D - 1) : r_rp - 1'b1;
        end
        if (i_cmd.div_start) begin
            r_div <= r_hi + 1'b1;
        end
    end

    // accumulate and divide, one lane per channel
    for (genvar c = 0; c < NCH; c++) begin : g_lane
        logic [CNT_W:0] rem_sh;
        always_comb begin
            rem_sh = {r_rem[c], r_quo[c][SUM_W-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_cmd.setup) begin
                r_acc[c] <= '0;
            end else if (r_rd_vld) begin
                r_acc[c] <= r_acc[c] + SUM_W'(r_rd_data[c*CW +: CW]);
            end
            if (i_cmd.div_start) begin
                r_rem[c] <= '0;
                r_quo[c] <= r_acc[c];
            end else if (r_dcnt != '0) begin
                if (rem_sh >= {1'b0, r_div}) begin
                    r_rem[c] <= CNT_W'(rem_sh - {1'b0, r_div});
                    r_quo[c] <= {r_quo[c][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= CNT_W'(rem_sh);
                    r_quo[c] <= {r_quo[c][SUM_W-2:0], 1'b0};
                end
            end
        end
        always_comb begin
            if (32'(c) >= 32'(r_cc)) begin
                out_word[c*CW +: CW] = '0;
            end else if (r_quo[c] > SUM_W'(255)) begin
                out_word[c*CW +: CW] = 8'hFF;
            end else begin
                out_word[c*CW +: CW] = r_quo[c][CW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= out_word;
            r_out_last <= r_row_end && (r_d == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

@@ sv/row_box_filter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// row_box_filter
// Horizontal box filter over one row: each output pixel is the truncated
// per-channel mean over a window clipped to the row.
//
//   channel   direction  word contents (low bits first)
//   s_axis    in         tdata: chan0, chan1, chan2, chan3; tlast: row end
//   m_axis    out        tdata: chan0, chan1, chan2, chan3; tlast: row end
//   cfg       in         index 0 radius, index 1 channel_count
//
// One pixel at a time. The sequencer accepts and plans a pixel; each result
// then takes a window setup, the W history reads (W = window size, one read per
// cycle from the single history port), a drain, a divider load, the restoring
// divide and an output load. A row end flushes up to radius more results
// through the same sequence. A stalled output holds the sequencer at the
// output load. Reset is synchronous, active low.
// ---------------------------------------------------------------------------
module row_box_filter #(
    parameter int MAX_RADIUS     = rbf_pkg::DEF_MAX_RADIUS,
    parameter int MAX_ROW_PIXELS = rbf_pkg::DEF_MAX_ROW_PIXELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rbf_pkg::PIX_W-1:0]     s_axis_tdata,   // chan0, chan1, chan2, chan3
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rbf_pkg::PIX_W-1:0]     m_axis_tdata,   // chan0, chan1, chan2, chan3
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [rbf_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [rbf_pkg::RAD_W-1:0]     i_cfg_wdata
);

    rbf_pkg::t_cmd    cmd;
    rbf_pkg::t_status status;

    logic [rbf_pkg::RAD_W-1:0] r_radius;
    logic [rbf_pkg::CC_W-1:0]  r_channel_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius        <= rbf_pkg::RAD_W'(1);
            r_channel_count <= rbf_pkg::CC_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rbf_pkg::REG_RADIUS:        r_radius <= i_cfg_wdata;
                rbf_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata[rbf_pkg::CC_W-1:0];
                default: ;
            endcase
        end
    end

    rbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rbf_dp #(
        .MAX_RADIUS     (MAX_RADIUS),
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_pix           (s_axis_tdata),
        .i_row_end       (s_axis_tlast),
        .i_radius        (r_radius),
        .i_channel_count (r_channel_count),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_out_data      (m_axis_tdata),
        .o_out_last      (m_axis_tlast)
    );

    // a result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output load while output register busy");

    // an accepted pixel blocks the input on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // history reads and divider load never overlap
    a_issue_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !cmd.div_start)
        else $error("read issued during divider load");

endmodule

@@ tb/sv/tb_row_box_filter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_row_box_filter
// Self-checking regression for the row box filter. Pixel rows go into the
// slave stream. A local running model of the clipped-window mean queues the
// expected output words. A checker compares each accepted output word with
// the oldest queued word. Radius and channel count are swept between phases,
// including the out-of-range register codes. Both stream sides idle and
// stall at random.
// ---------------------------------------------------------------------------
module tb_row_box_filter;
    import rbf_pkg::*;

    localparam int HIST_LEN   = 2 * DEF_MAX_RADIUS + 2;
    localparam int SETTLE_CYC = 200;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
    } t_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [PIX_W-1:0]   s_axis_tdata = '0;   // chan0, chan1, chan2, chan3
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [PIX_W-1:0]   m_axis_tdata;        // chan0, chan1, chan2, chan3
    logic               m_axis_tlast;
    logic               i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0] i_cfg_addr = '0;
    logic [RAD_W-1:0]   i_cfg_wdata = '0;

    // model state
    logic [PIX_W-1:0] hist [HIST_LEN];
    int               hist_wr;
    int               row_pos;
    int               radius_reg;
    int               chan_reg;
    t_word            mean_q[$];

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_req;
    int hold_left;
    int mismatches;

    row_box_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Mean of the window reaching d + r pixels behind the newest one.
    function automatic t_word window_mean(int d, int r, int n, int cc);
        t_word w;
        int    hi;
        int    sum;
        hi = d + r;
        if (hi > n - 1) hi = n - 1;
        w = '0;
        for (int c = 0; c < NCHAN; c++) begin
            sum = 0;
            for (int k = 0; k <= hi; k++)
                sum += hist[(hist_wr + HIST_LEN - k) % HIST_LEN][CHAN_W*c +: CHAN_W];
            if (c < cc) w.pix[CHAN_W*c +: CHAN_W] = sum / (hi + 1);
        end
        return w;
    endfunction

    // Advance the model by one accepted pixel and queue its output words.
    function automatic void predict_means(logic [PIX_W-1:0] pix, logic last);
        int r;
        int cc;
        int n;
        int first_d;
        int produced;
        r  = (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius_reg;
        cc = (chan_reg == 0) ? 1 : ((chan_reg > NCHAN) ? NCHAN : chan_reg);
        hist_wr = (hist_wr + 1) % HIST_LEN;
        hist[hist_wr] = pix;
        if (row_pos < DEF_MAX_ROW_PIXELS - 1) row_pos++;
        n = row_pos;
        produced = 0;
        if (n - 1 >= r) begin
            mean_q.push_back(window_mean(r, r, n, cc));
            produced++;
            first_d = r - 1;
        end else begin
            first_d = n - 1;
        end
        if (last) begin
            // flush the outputs still owed for this row
            for (int d = first_d; d >= 0; d--) begin
                mean_q.push_back(window_mean(d, r, n, cc));
                produced++;
            end
            if (produced > 0) mean_q[$].last = 1'b1;
            row_pos = 0;
        end
    endfunction

    // Check each accepted output word against the oldest expectation.
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mean_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data %h last %b", m_axis_tdata, m_axis_tlast);
            end else begin
                want = mean_q.pop_front();
                if (want.pix !== m_axis_tdata || want.last !== m_axis_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected data %h last %b, got data %h last %b",
                                 want.pix, want.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // Drive master ready: random stalls, or a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Send one pixel word; called at a falling edge, returns at one.
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_means(pix, last);
        @(negedge i_clk);
    endtask

    task automatic send_row(int len);
        for (int i = 0; i < len; i++) send_pixel($urandom, i == len - 1);
    endtask

    // Wait until every expected word has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (mean_q.size() != 0) @(negedge i_clk);
    endtask

    // Write one register while the block is idle.
    task automatic set_reg(logic [CFG_A_W-1:0] idx, int val);
        drain();
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[RAD_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_RADIUS) radius_reg = val;
        else chan_reg = val;
    endtask

    // Field extremes, every radius and channel-count corner.
    task automatic test_directed();
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hAA55_AA55, 1'b0);
        send_pixel(32'h55AA_55AA, 1'b1);
        send_pixel(32'h1234_5678, 1'b1);      // one-pixel row
        set_reg(REG_RADIUS, 0);                // pass-through
        send_row(3);
        set_reg(REG_RADIUS, DEF_MAX_RADIUS);   // whole row flushed at the end
        send_row(5);
        set_reg(REG_RADIUS, 63);               // clamps to the maximum
        send_row(3);
        set_reg(REG_RADIUS, 1);
        set_reg(REG_CHANNEL_COUNT, 0);         // acts as one channel
        send_row(2);
        set_reg(REG_CHANNEL_COUNT, 7);         // acts as four
        send_row(2);
        for (int c = 1; c <= 3; c++) begin
            set_reg(REG_CHANNEL_COUNT, c);
            send_pixel(32'hFFFF_FFFF, 1'b1);
        end
        set_reg(REG_CHANNEL_COUNT, NCHAN);
    endtask

    // Change the radius in the middle of a row.
    task automatic test_radius_mid_row();
        set_reg(REG_RADIUS, 2);
        for (int i = 0; i < 4; i++) send_pixel($urandom, 1'b0);
        set_reg(REG_RADIUS, 5);
        send_row(3);
    endtask

    // Fill the block behind a stalled receiver, then pause the sender.
    task automatic test_back_pressure();
        set_reg(REG_RADIUS, 3);
        hold_req = 600;
        for (int i = 0; i < 30; i++) send_pixel($urandom, 1'b0);
        drain();
        send_row(12);
        drain();
    endtask

    // Random rows under a random configuration, about n_items pixels.
    task automatic test_random_rows(int n_items);
        int sent;
        int r;
        int len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) r = $urandom_range(1, 4);
            else if (pick < 90) r = $urandom_range(0, 8);
            else r = $urandom_range(9, 63);
            set_reg(REG_RADIUS, r);
            set_reg(REG_CHANNEL_COUNT, $urandom_range(0, 7));
            for (int row = 0; row < $urandom_range(2, 4); row++) begin
                if (r > 8) len = $urandom_range(1, 12);
                else if ($urandom_range(9) == 0) len = $urandom_range(20, 70);
                else len = $urandom_range(1, 2 * r + 6);
                send_row(len);
                sent += len;
            end
        end
    endtask

    initial begin
        snd_idle_pct = 33;
        rcv_idle_pct = 53;
        hold_req     = 0;
        hold_left    = 0;
        mismatches   = 0;
        hist_wr      = 0;
        row_pos      = 0;
        radius_reg   = 1;
        chan_reg     = NCHAN;
        for (int i = 0; i < HIST_LEN; i++) hist[i] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_radius_mid_row();
        test_random_rows(50);
        snd_idle_pct = 53;
        rcv_idle_pct = 33;
        test_random_rows(50);
        test_back_pressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_rows(50);

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("row_box_filter regression: pass");
        end else begin
            $display("row_box_filter regression: fail");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #4_000_000;
        $display("row_box_filter regression: fail");
        $finish;
    end

endmodule

@@ row_box_filter.f @@
sv/rbf_pkg.sv
sv/rbf_ctrl.sv
sv/rbf_dp.sv
sv/row_box_filter.sv
tb/sv/tb_row_box_filter.sv
